### rtl/hce_pkg.sv
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types, constants and step functions for the homography corner error
// pipeline.
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int NUM_CORNERS = 4;
  localparam int NUM_LANES   = 2 * NUM_CORNERS;
  localparam int DIV_STAGES  = 32;
  localparam int SQRT_STAGES = 32;
  localparam int FRAC_SHIFT  = 14;

  typedef logic signed [31:0] coef_t;
  typedef logic signed [33:0] hvec_t;   // x, y or w of one corner
  typedef logic [33:0]        mag_t;    // |nx|, |ny|, |w|, remainders
  typedef logic [31:0]        quo_t;
  typedef logic [63:0]        rad_t;

  // corner signs: corner 0 (-1,-1), 1 (-1,+1), 2 (+1,+1), 3 (+1,-1)
  localparam logic [NUM_CORNERS-1:0] NEG_SX = 4'b0011;
  localparam logic [NUM_CORNERS-1:0] NEG_SY = 4'b1001;

  function automatic hvec_t corner_sum(coef_t a, coef_t b, coef_t c,
                                       logic neg_a, logic neg_b);
    hvec_t ea;
    hvec_t eb;
    ea = hvec_t'(a);
    eb = hvec_t'(b);
    if (neg_a) ea = -ea;
    if (neg_b) eb = -eb;
    return ea + eb + hvec_t'(c);
  endfunction

  typedef struct packed {
    mag_t rem;
    quo_t lo;   // dividend bits still to bring down
    quo_t quo;
  } div_t;

  function automatic div_t div_step(div_t d, mag_t dvs);
    logic [34:0] t;
    div_t r;
    t = {d.rem, d.lo[31]};
    r.lo = {d.lo[30:0], 1'b0};
    if (t >= {1'b0, dvs}) begin
      r.rem = mag_t'(t - {1'b0, dvs});
      r.quo = {d.quo[30:0], 1'b1};
    end else begin
      r.rem = t[33:0];
      r.quo = {d.quo[30:0], 1'b0};
    end
    return r;
  endfunction

  typedef struct packed {
    mag_t rem;
    rad_t rad;
    quo_t root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [35:0] t;
    logic [35:0] trial;
    sqrt_t r;
    t = {s.rem, s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (t >= trial) begin
      r.rem = mag_t'(t - trial);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem = t[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/homography_corner_error.sv
// ----------------------------------------------------------------------------
// homography_corner_error
// Maps the four corners (+-1, +-1) through a Q12.20 homography and returns
// the mean corner displacement in Q16.16, saturated, with a degenerate flag.
// ----------------------------------------------------------------------------
// throughput: one matrix per cycle unless the pipeline holds; 32 restoring
// divide stages and 32 square root stages, one result bit each, set the depth
// the whole pipeline holds when a result waits and out_ready is low
// reset clears all valid bits; data registers are not reset
module homography_corner_error
  import hce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] h00,
  input  logic [31:0] h01,
  input  logic [31:0] h02,
  input  logic [31:0] h10,
  input  logic [31:0] h11,
  input  logic [31:0] h12,
  input  logic [31:0] h20,
  input  logic [31:0] h21,
  input  logic [31:0] h22,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] mean_error,
  output logic        degenerate
);

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // input register
  logic  v_in;
  coef_t m [9];

  // x, y, w per corner
  logic  v_xyw;
  hvec_t cx [NUM_CORNERS];
  hvec_t cy [NUM_CORNERS];
  hvec_t cw [NUM_CORNERS];

  // divider lanes: lane 2c is x of corner c, 2c+1 is y
  logic [DIV_STAGES:0] v_div;
  div_t dst  [NUM_LANES][DIV_STAGES+1];
  mag_t dvs  [NUM_LANES][DIV_STAGES+1];
  logic dbad [NUM_LANES][DIV_STAGES+1];

  logic v_sq;
  rad_t sq   [NUM_LANES];
  logic sqbad [NUM_LANES];

  logic [SQRT_STAGES:0] v_rt;
  sqrt_t rst_s [NUM_CORNERS][SQRT_STAGES+1];
  logic  rbad  [NUM_CORNERS][SQRT_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
      v_xyw <= 1'b0;
      v_div <= '0;
      v_sq <= 1'b0;
      v_rt <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_in <= in_valid;
      v_xyw <= v_in;
      v_div <= {v_div[DIV_STAGES-1:0], v_xyw};
      v_sq <= v_div[DIV_STAGES];
      v_rt <= {v_rt[SQRT_STAGES-1:0], v_sq};
      out_valid <= v_rt[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= h00; m[1] <= h01; m[2] <= h02;
      m[3] <= h10; m[4] <= h11; m[5] <= h12;
      m[6] <= h20; m[7] <= h21; m[8] <= h22;
    end
  end

  genvar c, l, k;
  generate
    for (c = 0; c < NUM_CORNERS; c++) begin : g_corner
      always_ff @(posedge clk) begin
        if (en) begin
          cx[c] <= corner_sum(m[0], m[1], m[2], NEG_SX[c], NEG_SY[c]);
          cy[c] <= corner_sum(m[3], m[4], m[5], NEG_SX[c], NEG_SY[c]);
          cw[c] <= corner_sum(m[6], m[7], m[8], NEG_SX[c], NEG_SY[c]);
        end
      end
    end

    for (l = 0; l < NUM_LANES; l++) begin : g_lane
      localparam int CN = l / 2;
      localparam logic NEG_S = (l % 2 == 0) ? NEG_SX[l/2] : NEG_SY[l/2];
      logic signed [34:0] sw;
      logic signed [34:0] nv;
      mag_t an;
      mag_t aw;

      always_comb begin
        sw = {cw[CN][33], cw[CN]};
        if (NEG_S) sw = -sw;
        nv = sw - ((l % 2 == 0) ? {cx[CN][33], cx[CN]} : {cy[CN][33], cy[CN]});
        an = nv[34] ? mag_t'(-nv) : mag_t'(nv);
        aw = cw[CN][33] ? mag_t'(-cw[CN]) : mag_t'(cw[CN]);
      end

      // quotient reaches 2^32 exactly when |n| >= |w| * 2^18
      always_ff @(posedge clk) begin
        if (en) begin
          dst[l][0].rem <= mag_t'(an[33:18]);
          dst[l][0].lo  <= {an[17:0], {FRAC_SHIFT{1'b0}}};
          dst[l][0].quo <= '0;
          dvs[l][0]     <= aw;
          dbad[l][0]    <= (cw[CN] == '0) ||
                           ({18'd0, an} >= {aw, 18'd0});
        end
      end

      for (k = 0; k < DIV_STAGES; k++) begin : g_div
        always_ff @(posedge clk) begin
          if (en) begin
            dst[l][k+1]  <= div_step(dst[l][k], dvs[l][k]);
            dvs[l][k+1]  <= dvs[l][k];
            dbad[l][k+1] <= dbad[l][k];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sq[l]    <= rad_t'(dst[l][DIV_STAGES].quo) * rad_t'(dst[l][DIV_STAGES].quo);
          sqbad[l] <= dbad[l][DIV_STAGES];
        end
      end
    end

    for (c = 0; c < NUM_CORNERS; c++) begin : g_root
      logic [64:0] ssum;
      assign ssum = {1'b0, sq[2*c]} + {1'b0, sq[2*c+1]};

      always_ff @(posedge clk) begin
        if (en) begin
          rst_s[c][0].rem  <= '0;
          rst_s[c][0].rad  <= ssum[63:0];
          rst_s[c][0].root <= '0;
          rbad[c][0]       <= sqbad[2*c] || sqbad[2*c+1] || ssum[64];
        end
      end

      for (k = 0; k < SQRT_STAGES; k++) begin : g_sq
        always_ff @(posedge clk) begin
          if (en) begin
            rst_s[c][k+1] <= sqrt_step(rst_s[c][k]);
            rbad[c][k+1]  <= rbad[c][k];
          end
        end
      end
    end
  endgenerate

  logic [33:0] total;
  logic        any_bad;
  always_comb begin
    total = {2'b00, rst_s[0][SQRT_STAGES].root} + {2'b00, rst_s[1][SQRT_STAGES].root}
          + {2'b00, rst_s[2][SQRT_STAGES].root} + {2'b00, rst_s[3][SQRT_STAGES].root};
    any_bad = rbad[0][SQRT_STAGES] || rbad[1][SQRT_STAGES] ||
              rbad[2][SQRT_STAGES] || rbad[3][SQRT_STAGES] || (total[33:32] != 2'b00);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mean_error <= any_bad ? 32'hFFFF_FFFF : total[31:0];
      degenerate <= any_bad;
    end
  end

  // a degenerate result always carries the saturated value
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> mean_error == 32'hFFFF_FFFF)
    else $error("degenerate result not saturated");

  // an accepted request is captured in the input register
  a_adv: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v_in)
    else $error("accepted request lost at entry");

  // a waiting result holds the divide and square root valid bits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(v_rt) && $stable(v_div))
    else $error("pipeline moved while result waits");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds homographies to homography_corner_error through a queue-fed driver,
// predicts each corner error in exact integer arithmetic and checks every
// result in order, under several phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench
  import hce_pkg::*;
();

  localparam int LATENCY   = 70;
  localparam int WDOG_MAX  = 5000;
  localparam int HOLD_LEN  = 300;

  localparam logic [31:0] ONE = 32'h0010_0000;
  localparam logic [31:0] MX  = 32'h7FFF_FFFF;
  localparam logic [31:0] MN  = 32'h8000_0000;

  typedef struct {
    logic [31:0] h [9];
  } matrix_t;

  typedef struct {
    logic [31:0] err;
    logic        degen;
  } score_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
  logic out_valid;
  logic out_ready;
  logic [31:0] mean_error;
  logic degenerate;

  homography_corner_error dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .h00(h00), .h01(h01), .h02(h02),
    .h10(h10), .h11(h11), .h12(h12),
    .h20(h20), .h21(h21), .h22(h22),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_error(mean_error), .degenerate(degenerate)
  );

  matrix_t pending_mats[$];
  score_t  expected_scores[$];
  int      errors;
  int      sent;
  int      checked;
  int      degen_seen;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_cycles;
  int      idle_cycles;
  bit      hold_req;
  bit      hold_taken;

  initial clk = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic queue_mat(matrix_t m);
    pending_mats.insert(pending_mats.size(), m);
  endtask

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic score_t corner_error(matrix_t m);
    longint c [9];
    longint sx, sy, x, y, w, nx, ny;
    logic [127:0] aw, qx, qy;
    logic [127:0] sq;
    logic [127:0] total;
    bit bad;
    score_t r;
    for (int i = 0; i < 9; i++) c[i] = longint'($signed(m.h[i]));
    total = 0;
    bad = 0;
    for (int k = 0; k < 4 && !bad; k++) begin
      sx = (k < 2) ? -1 : 1;
      sy = (k == 0 || k == 3) ? -1 : 1;
      x = sx * c[0] + sy * c[1] + c[2];
      y = sx * c[3] + sy * c[4] + c[5];
      w = sx * c[6] + sy * c[7] + c[8];
      if (w == 0) begin
        bad = 1;
      end else begin
        nx = sx * w - x;
        ny = sy * w - y;
        aw = (w < 0) ? -w : w;
        qx = (128'((nx < 0) ? -nx : nx) << FRAC_SHIFT) / aw;
        qy = (128'((ny < 0) ? -ny : ny) << FRAC_SHIFT) / aw;
        if (qx > 128'hFFFF_FFFF || qy > 128'hFFFF_FFFF) begin
          bad = 1;
        end else begin
          sq = qx * qx + qy * qy;
          if (sq >= (128'd1 << 64)) bad = 1;
          else begin
            total = total + int_sqrt(sq[63:0]);
            if (total > 128'hFFFF_FFFF) bad = 1;
          end
        end
      end
    end
    r.err = bad ? 32'hFFFF_FFFF : total[31:0];
    r.degen = bad;
    return r;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 4194304)) - 2097152);
      2: return 32'($signed($urandom_range(0, 2048)) - 1024);
      3: return 32'h0010_0000 + 32'($signed($urandom_range(0, 65536)) - 32768);
      4: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  // kinds 0 to 5 give near-identity matrices that keep w well away from zero, so errors stay finite
  function automatic matrix_t rand_matrix(int kind);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.h[i] = rand_coef();
    if (kind < 6) begin
      for (int i = 0; i < 9; i++)
        m.h[i] = 32'($signed($urandom_range(0, 1 << (8 + kind * 2))) -
                     (1 << (7 + kind * 2)));
      m.h[0] = m.h[0] + 32'h0010_0000;
      m.h[4] = m.h[4] + 32'h0010_0000;
      m.h[8] = m.h[8] + 32'h0010_0000;
    end else if (kind == 6) begin
      // force w of one corner to zero
      m.h[8] = 32'(-($signed(m.h[6]) * ($urandom_range(0, 1) ? 1 : -1)) -
                   ($signed(m.h[7]) * ($urandom_range(0, 1) ? 1 : -1)));
    end
    return m;
  endfunction

  function automatic matrix_t make_mat(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                       logic [31:0] d, logic [31:0] e, logic [31:0] f,
                                       logic [31:0] g, logic [31:0] p, logic [31:0] q);
    matrix_t m;
    m.h = '{a, b, c, d, e, f, g, p, q};
    return m;
  endfunction

  initial begin
    // identity, zero error
    queue_mat(make_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    // pure shift and scale
    queue_mat(make_mat(ONE, 0, ONE, 0, ONE, 0, 0, 0, ONE));
    queue_mat(make_mat(2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, ONE));
    queue_mat(make_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, 3 * ONE));
    // negative w everywhere
    queue_mat(make_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    // all zero: w is zero
    queue_mat(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // w zero at two corners
    queue_mat(make_mat(ONE, 0, 0, 0, ONE, 0, ONE, 0, ONE));
    queue_mat(make_mat(ONE, 0, 0, 0, ONE, 0, 0, ONE, ONE));
    // tiny w, huge numerator: component overflow
    queue_mat(make_mat(MX, MX, MX, MX, MX, MX, 0, 0, 1));
    queue_mat(make_mat(MN, MN, MN, MN, MN, MN, 0, 0, 1));
    // small w overflows a component; a 64x scale over unit w gives a finite error
    queue_mat(make_mat(MX, 0, 0, 0, MX, 0, 0, 0, 32'd64));
    queue_mat(make_mat(ONE << 6, 0, 0, 0, ONE << 6, 0, 0, 0, ONE));
    // field extremes
    queue_mat(make_mat(MX, MX, MX, MX, MX, MX, MX, MX, MX));
    queue_mat(make_mat(MN, MN, MN, MN, MN, MN, MN, MN, MN));
    queue_mat(make_mat(MX, MN, MX, MN, MX, MN, MX, MN, MX));
    queue_mat(make_mat(MN, MX, MN, MX, MN, MX, MN, MX, MN));
    queue_mat(make_mat(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
                       1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF));
    queue_mat(make_mat(0, 0, 0, 0, 0, 0, 0, 0, MX));
    queue_mat(make_mat(0, 0, 0, 0, 0, 0, 0, 0, MN));
    for (int i = 0; i < 1030; i++)
      queue_mat(rand_matrix($urandom_range(0, 9)));
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      {h00, h01, h02, h10, h11, h12, h20, h21, h22} <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_mats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        matrix_t m;
        m = pending_mats.pop_front();
        in_valid <= 1'b1;
        {h00, h01, h02, h10, h11, h12, h20, h21, h22} <=
          {m.h[0], m.h[1], m.h[2], m.h[3], m.h[4], m.h[5], m.h[6], m.h[7], m.h[8]};
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // record each accepted request's prediction
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      matrix_t m;
      m = make_mat(h00, h01, h02, h10, h11, h12, h20, h21, h22);
      expected_scores.insert(expected_scores.size(), corner_error(m));
      sent++;
    end
  end

  // receiver ready, with one long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_scores.size() == 0) begin
        $display("%0t: unexpected result err=%h degen=%b", $time, mean_error, degenerate);
        errors++;
      end else begin
        score_t e;
        e = expected_scores.pop_front();
        if (mean_error !== e.err) begin
          $display("%0t: mean_error expected %h actual %h", $time, e.err, mean_error);
          errors++;
        end
        if (degenerate !== e.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, e.degen, degenerate);
          errors++;
        end
        if (e.degen) degen_seen++;
        checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || hold_cycles > 0) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("%0t: watchdog expired", $time);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // no idling
    wait (sent >= 200);
    @(posedge clk);
    send_idle_pct = 71;
    wait (sent >= 400);
    @(posedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 71;
    wait (sent >= 600);
    @(posedge clk);
    // receiver holds off long enough to back up the pipeline
    recv_stall_pct = 0;
    hold_req = 1'b1;
    wait (sent >= 750);
    @(posedge clk);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    wait (sent >= 900);
    @(posedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait (pending_mats.size() == 0 && !in_valid);
    wait (expected_scores.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d matrices, %0d results checked, %0d degenerate", sent, checked,
             degen_seen);
    $display("phases: free flow, sender gaps, receiver stalls, long hold-off, mixed");
    if (errors == 0 && expected_scores.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
